// ===== hdl/llnp_pkg.sv =====
// Package: shared constants, word types, command/status structs and helpers for the node pool.
`default_nettype none
package llnp_pkg;

    localparam int POOL_DEPTH_DEF = 64;

    localparam int IDX_W   = 6;
    localparam int NUM_W   = 32;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int FRESH_W = 7;

    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [IDX_W-1:0] node;
        logic [NUM_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] handle;
        logic [NUM_W-1:0] stored_number;
        logic [ST_W-1:0]  status;
        logic             last;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;     // capture the request word
        logic take_fresh;  // allocate from the bump pointer
        logic pop_rd;      // read the link of the free-list head
        logic pop_free;    // allocate the free-list head, advance the free list
        logic commit;      // write the allocated node and emit its handle
        logic push_cur;    // push the current node onto the free list
        logic walk_rd;     // read number and link of the current node
        logic walk_adv;    // step to the next node of the walk
        logic emit_dump;   // emit the current node's number
        logic emit_resp;   // emit the single closing word
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cur_zero;
        logic            free_empty;
        logic            fresh_avail;
        logic            fin;
        logic            out_free;
    } stat_t;

    // Indices at or above the pool depth read as the empty list
    function automatic logic [IDX_W-1:0] clip_idx(input logic [IDX_W-1:0] v,
                                                  input int unsigned depth);
        logic [IDX_W-1:0] r;
        r = (32'(v) < depth) ? v : '0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/llnp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module llnp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hdl/llnp_dp.sv =====
// Datapath: node memories, free-list head, bump pointer, walk registers and result register.
`default_nettype none
module llnp_dp #(
    parameter int POOL_DEPTH = llnp_pkg::POOL_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  llnp_pkg::req_t req,
    input  llnp_pkg::cmd_t cmd,
    output llnp_pkg::stat_t stat,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output llnp_pkg::rsp_t rsp
);

    import llnp_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);

    logic [OP_W-1:0]    op_reg, op_next;
    logic [NUM_W-1:0]   value_reg, value_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]   alloc_reg, alloc_next;
    logic [IDX_W-1:0]   free_head_reg, free_head_next;
    logic [FRESH_W-1:0] next_fresh_reg, next_fresh_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [IDX_W-1:0] link_rdata;
    logic [NUM_W-1:0] num_rdata;
    logic [IDX_W-1:0] nx;
    logic             fin;
    logic             emit;
    logic             is_insert;
    logic [ST_W-1:0]  resp_status;

    logic             link_we, link_re;
    logic [IDX_W-1:0] link_waddr, link_raddr, link_wdata;
    logic [NUM_W-1:0] num_wdata;

    assign nx        = clip_idx(link_rdata, POOL_DEPTH);
    assign fin       = (nx == '0) || (cnt_reg == AW'(POOL_DEPTH - 2));
    assign is_insert = (op_reg == OP_INSERT);
    assign emit      = cmd.commit || cmd.emit_dump || cmd.emit_resp;

    always_comb
    begin
        case (op_reg)
            OP_CREATE, OP_INSERT: resp_status = ST_NO_SPACE;
            OP_DUMP:              resp_status = ST_EMPTY;
            default:              resp_status = ST_OK;
        endcase
    end

    // Memory ports
    assign link_we    = cmd.commit || cmd.push_cur;
    assign link_waddr = cmd.commit ? alloc_reg : cur_reg;
    assign link_wdata = cmd.commit ? (is_insert ? cur_reg : '0) : free_head_reg;
    assign link_re    = cmd.pop_rd || cmd.walk_rd;
    assign link_raddr = cmd.pop_rd ? free_head_reg : cur_reg;
    assign num_wdata  = is_insert ? value_reg : '0;

    llnp_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr[AW-1:0]),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr[AW-1:0]),
        .rdata (link_rdata)
    );

    llnp_ram #(.WIDTH(NUM_W), .DEPTH(POOL_DEPTH)) u_num_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (alloc_reg[AW-1:0]),
        .wdata (num_wdata),
        .re    (cmd.walk_rd),
        .raddr (cur_reg[AW-1:0]),
        .rdata (num_rdata)
    );

    always_comb
    begin
        op_next         = cmd.load_in ? req.operation : op_reg;
        value_next      = cmd.load_in ? req.value : value_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        alloc_next      = alloc_reg;
        free_head_next  = free_head_reg;
        next_fresh_next = next_fresh_reg;

        if (cmd.load_in)
        begin
            cur_next = clip_idx(req.node, POOL_DEPTH);
            cnt_next = '0;
        end
        else if (cmd.walk_adv)
        begin
            cur_next = nx;
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.take_fresh)
        begin
            alloc_next      = next_fresh_reg[IDX_W-1:0];
            next_fresh_next = next_fresh_reg + 1'b1;
        end
        else if (cmd.pop_free)
        begin
            alloc_next     = free_head_reg;
            free_head_next = nx;
        end
        else if (cmd.push_cur)
        begin
            free_head_next = cur_reg;
        end
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (cmd.commit)
        begin
            rsp_next = '{handle: alloc_reg, stored_number: '0, status: ST_OK, last: 1'b1};
        end
        else if (cmd.emit_dump)
        begin
            rsp_next = '{handle: '0, stored_number: num_rdata, status: ST_OK, last: fin};
        end
        else if (cmd.emit_resp)
        begin
            rsp_next = '{handle: '0, stored_number: '0, status: resp_status, last: 1'b1};
        end
        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            next_fresh_reg <= FRESH_W'(1);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            next_fresh_reg <= next_fresh_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        cur_reg   <= cur_next;
        cnt_reg   <= cnt_next;
        alloc_reg <= alloc_next;
        rsp_reg   <= rsp_next;
    end

    assign stat.op          = op_reg;
    assign stat.cur_zero    = (cur_reg == '0);
    assign stat.free_empty  = (free_head_reg == '0);
    assign stat.fresh_avail = (32'(next_fresh_reg) < POOL_DEPTH);
    assign stat.fin         = fin;
    assign stat.out_free    = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A result may only be loaded when the output slot is empty or being drained
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!rsp_valid_reg || rsp_ready))
        else $error("result loaded over an undelivered word");

    // The bump pointer moves only on a fresh allocation
    a_fresh_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.take_fresh |=> $stable(next_fresh_reg))
        else $error("bump pointer moved without an allocation");

    // A fresh allocation never hands out node 0 or a node past the pool
    a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_fresh |-> (next_fresh_reg != '0 && 32'(next_fresh_reg) < POOL_DEPTH))
        else $error("bump pointer out of range at allocation");

endmodule
`default_nettype wire

// ===== hdl/llnp_ctrl.sv =====
// Controller: state machine that sequences each operation through the datapath.
`default_nettype none
module llnp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  llnp_pkg::stat_t stat,
    output llnp_pkg::cmd_t  cmd
);

    import llnp_pkg::*;

    localparam int SW = 4;
    localparam logic [SW-1:0] S_IDLE      = 4'd0;
    localparam logic [SW-1:0] S_DISPATCH  = 4'd1;
    localparam logic [SW-1:0] S_ALLOC_POP = 4'd2;
    localparam logic [SW-1:0] S_COMMIT    = 4'd3;
    localparam logic [SW-1:0] S_REL_RD    = 4'd4;
    localparam logic [SW-1:0] S_REL_WR    = 4'd5;
    localparam logic [SW-1:0] S_DUMP_RD   = 4'd6;
    localparam logic [SW-1:0] S_DUMP_EMIT = 4'd7;
    localparam logic [SW-1:0] S_RESP      = 4'd8;

    logic [SW-1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_CREATE, OP_INSERT:
                    begin
                        if (!stat.free_empty)
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_ALLOC_POP;
                        end
                        else if (stat.fresh_avail)
                        begin
                            cmd.take_fresh = 1'b1;
                            state_next     = S_COMMIT;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    OP_DELETE:
                    begin
                        cmd.push_cur = !stat.cur_zero;
                        state_next   = S_RESP;
                    end
                    OP_RELEASE:
                    begin
                        state_next = stat.cur_zero ? S_RESP : S_REL_RD;
                    end
                    OP_DUMP:
                    begin
                        state_next = stat.cur_zero ? S_RESP : S_DUMP_RD;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_ALLOC_POP:
            begin
                cmd.pop_free = 1'b1;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REL_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_REL_WR;
            end
            S_REL_WR:
            begin
                cmd.push_cur = 1'b1;
                cmd.walk_adv = 1'b1;
                state_next   = stat.fin ? S_RESP : S_REL_RD;
            end
            S_DUMP_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_DUMP_EMIT;
            end
            S_DUMP_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_dump = 1'b1;
                    cmd.walk_adv  = 1'b1;
                    state_next    = stat.fin ? S_IDLE : S_DUMP_RD;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_resp = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // At most one result source per cycle
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.commit, cmd.emit_dump, cmd.emit_resp}))
        else $error("two result sources in one cycle");

    // An accepted word is worked on before the next is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while the previous one is in progress");

endmodule
`default_nettype wire

// ===== hdl/linked_list_node_pool_top.sv =====
// Top level: node pool with free list, joining the controller and the datapath.
//
// A fixed pool of POOL_DEPTH list nodes (node 0 is the end-of-list mark and
// is never handed out), each with a 32-bit number and a link. Allocation takes
// the head of the free list first, then a fresh node from a bump pointer
// starting at 1; when both are used up, create and insert return handle 0
// with the out-of-space status and leave the pool untouched. One request word
// is worked on at a time, and the next is taken once the current one has
// placed its last result in the output register, so a finished result may
// wait there while the next request already runs. The link memory has a single
// read port with registered read data, so an allocation from the free list reads
// the head's link before it commits, while a fresh node commits directly; release
// and dump read each node and then free or emit it, and any result waits while
// the output side stalls. Walks visit at most POOL_DEPTH-1 nodes, which bounds
// lists made cyclic by freeing a node twice.
// The node memories need no clearing after reset; a node reads back
// meaningfully only once it has been allocated.
`default_nettype none
module linked_list_node_pool_top #(
    parameter int POOL_DEPTH = llnp_pkg::POOL_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  llnp_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output llnp_pkg::rsp_t rsp
);

    import llnp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequence each request word
    llnp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the pool, the free list and the output word
    llnp_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ===== bench/tb_linked_list_node_pool_top.sv =====
`timescale 1ns / 100ps
// Testbench for the linked-list node pool: a shadow pool predicts every result word.
module tb_linked_list_node_pool_top;
    import llnp_pkg::*;

    localparam int DEPTH        = POOL_DEPTH_DEF;
    localparam int HOLD_CYCLES  = 300;   // long output hold-off, counted by the receiver
    localparam int DRAIN_CYCLES = 40;    // quiet cycles after the last awaited word
    localparam int STALL_LIMIT  = 3000;  // cycles with no handshake before giving up

    // Operation codes the block does not know; it must answer them with a bare closing word
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    typedef enum int {MIX_BUILD, MIX_TEAR, MIX_BLEND} mix_t;

    // Shadow copy of the pool: node memories, free list and bump pointer, plus the words
    // the block still owes. The set flags track which entries hold a written value, so
    // that the stimulus never makes the block read an entry that was never written.
    class pool_shadow;
        logic [NUM_W-1:0]   num_mem  [DEPTH];
        logic [IDX_W-1:0]   link_mem [DEPTH];
        bit                 num_set  [DEPTH];
        bit                 link_set [DEPTH];
        logic [IDX_W-1:0]   free_head;
        logic [FRESH_W-1:0] next_fresh;
        logic [IDX_W-1:0]   last_alloc;
        rsp_t               awaited_words [$];
        int                 errors;

        function new();
            free_head  = '0;
            next_fresh = 1;
            last_alloc = '0;
            errors     = 0;
            foreach (num_set[i])
            begin
                num_set[i]  = 1'b0;
                link_set[i] = 1'b0;
            end
        endfunction

        function logic [IDX_W-1:0] to_index(logic [IDX_W-1:0] v);
            return (int'(v) < DEPTH) ? v : '0;
        endfunction

        // Work out the result words of one request on a copy of the pool. Return 0 if the
        // request would read an unwritten entry. Commit the copy only when asked and safe.
        function bit run_request(req_t word, bit apply);
            logic [NUM_W-1:0]   nums  [DEPTH];
            logic [IDX_W-1:0]   links [DEPTH];
            bit                 nset  [DEPTH];
            bit                 lset  [DEPTH];
            logic [IDX_W-1:0]   fh;
            logic [FRESH_W-1:0] nf;
            logic [IDX_W-1:0]   idx;
            logic [IDX_W-1:0]   cur;
            logic [IDX_W-1:0]   nxt;
            logic [IDX_W-1:0]   got;
            rsp_t               out_q [$];
            rsp_t               w;
            bit                 ok;
            int                 k;
            nums  = num_mem;
            links = link_mem;
            nset  = num_set;
            lset  = link_set;
            fh    = free_head;
            nf    = next_fresh;
            idx   = to_index(word.node);
            got   = '0;
            ok    = 1'b1;
            w     = '0;
            w.last = 1'b1;
            case (word.operation)
                OP_CREATE, OP_INSERT:
                begin
                    if (fh != '0)
                    begin
                        got = to_index(fh);
                        if (!(nset[got] && lset[got]))
                            ok = 1'b0;
                        fh = to_index(links[got]);
                    end
                    else if (int'(nf) < DEPTH)
                    begin
                        got = nf[IDX_W-1:0];
                        nf  = nf + 1'b1;
                    end
                    if (got == '0)
                        w.status = ST_NO_SPACE;
                    else
                    begin
                        nums[got]  = (word.operation == OP_INSERT) ? word.value : '0;
                        links[got] = (word.operation == OP_INSERT) ? idx : '0;
                        nset[got]  = 1'b1;
                        lset[got]  = 1'b1;
                        w.handle   = got;
                        w.status   = ST_OK;
                    end
                    out_q.push_back(w);
                end
                OP_DELETE:
                begin
                    // A node that never held a number would poison the free list
                    if (idx != '0)
                    begin
                        if (!nset[idx])
                            ok = 1'b0;
                        links[idx] = fh;
                        lset[idx]  = 1'b1;
                        fh         = idx;
                    end
                    out_q.push_back(w);
                end
                OP_RELEASE:
                begin
                    cur = idx;
                    k   = 0;
                    while (cur != '0 && k < DEPTH - 1)
                    begin
                        if (!(nset[cur] && lset[cur]))
                        begin
                            ok = 1'b0;
                            break;
                        end
                        nxt        = to_index(links[cur]);
                        links[cur] = fh;
                        fh         = cur;
                        cur        = nxt;
                        k++;
                    end
                    out_q.push_back(w);
                end
                OP_DUMP:
                begin
                    if (idx == '0)
                    begin
                        w.status = ST_EMPTY;
                        out_q.push_back(w);
                    end
                    cur = idx;
                    k   = 0;
                    // Cap the walk so that a cyclic list still ends
                    while (cur != '0 && k < DEPTH - 1)
                    begin
                        if (!(nset[cur] && lset[cur]))
                        begin
                            ok = 1'b0;
                            break;
                        end
                        nxt             = to_index(links[cur]);
                        w               = '0;
                        w.stored_number = nums[cur];
                        w.status        = ST_OK;
                        w.last          = (nxt == '0) || (k + 1 >= DEPTH - 1);
                        out_q.push_back(w);
                        cur = nxt;
                        k++;
                    end
                end
                default:
                    out_q.push_back(w);
            endcase
            if (apply && ok)
            begin
                num_mem    = nums;
                link_mem   = links;
                num_set    = nset;
                link_set   = lset;
                free_head  = fh;
                next_fresh = nf;
                if (got != '0)
                    last_alloc = got;
                foreach (out_q[j])
                    awaited_words.push_back(out_q[j]);
            end
            return ok;
        endfunction

        // Note an accepted request word
        function void take_request(req_t word);
            void'(run_request(word, 1'b1));
        endfunction

        // Compare an accepted result word with the oldest awaited one
        function void check_word(rsp_t got);
            rsp_t want;
            if (awaited_words.size() == 0)
            begin
                $error("unawaited result word: handle %0d number %h status %0d last %0b",
                       got.handle, got.stored_number, got.status, got.last);
                errors++;
                return;
            end
            want = awaited_words.pop_front();
            if (got.handle !== want.handle)
            begin
                $error("handle: expected %0d, actual %0d", want.handle, got.handle);
                errors++;
            end
            if (got.stored_number !== want.stored_number)
            begin
                $error("stored_number: expected %h, actual %h",
                       want.stored_number, got.stored_number);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction

        // Pick a node worth pointing at: mostly the newest head, else any written node
        function logic [IDX_W-1:0] pick_node();
            logic [IDX_W-1:0] c;
            if (last_alloc != '0 && $urandom_range(99) < 60)
                return last_alloc;
            repeat (8)
            begin
                c = IDX_W'($urandom_range(DEPTH - 1, 1));
                if (num_set[c] && link_set[c])
                    return c;
            end
            return '0;
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // steady: both sides run without idling; hold_start: ask the receiver for a long hold-off
    bit steady     = 1'b0;
    bit hold_start = 1'b0;

    pool_shadow shadow;

    linked_list_node_pool_top #(
        .POOL_DEPTH(POOL_DEPTH_DEF)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // Offer one request word, with a random gap in front, and hold it until accepted.
    // Sampling at the edge sees the values from before the edge, so the handshake is exact.
    task automatic send_word(input req_t word);
        int gap;
        if (!steady && $urandom_range(99) < 20)
        begin
            gap = $urandom_range(5, 1);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= word;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        shadow.take_request(word);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [NUM_W-1:0] num);
        req_t word;
        word.operation = op;
        word.node      = idx;
        word.value     = num;
        send_word(word);
    endtask

    // Draw a random request word; the mix decides whether lists mostly grow or shrink
    function automatic req_t make_item(mix_t mix);
        req_t word;
        int   roll;
        int   pick;
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        word.value = $urandom();
        case ($urandom_range(7))
            0: word.value = '0;
            1: word.value = '1;
            default: ;
        endcase
        if (pick < 70)
            word.node = shadow.pick_node();
        else if (pick < 82)
            word.node = '0;
        else
            word.node = IDX_W'($urandom_range(DEPTH - 1));
        case (mix)
            MIX_BUILD:
                if (roll < 70)      word.operation = OP_INSERT;
                else if (roll < 92) word.operation = OP_CREATE;
                else if (roll < 96) word.operation = OP_DUMP;
                else                word.operation = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            MIX_TEAR:
                if (roll < 20)      word.operation = OP_INSERT;
                else if (roll < 30) word.operation = OP_CREATE;
                else if (roll < 50) word.operation = OP_DELETE;
                else if (roll < 70) word.operation = OP_RELEASE;
                else if (roll < 94) word.operation = OP_DUMP;
                else                word.operation = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            default:
                if (roll < 35)      word.operation = OP_INSERT;
                else if (roll < 45) word.operation = OP_CREATE;
                else if (roll < 58) word.operation = OP_DELETE;
                else if (roll < 70) word.operation = OP_RELEASE;
                else if (roll < 94) word.operation = OP_DUMP;
                else                word.operation = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        endcase
        return word;
    endfunction

    // Send a run of random words. Redraw any word that would make the block read an
    // unwritten entry; if that keeps happening, fall back to a delete of the empty list.
    task automatic run_random(input mix_t mix, input int count);
        req_t word;
        int   tries;
        repeat (count)
        begin
            word  = make_item(mix);
            tries = 0;
            while (!shadow.run_request(word, 1'b0) && tries < 8)
            begin
                word = make_item(mix);
                tries++;
            end
            if (!shadow.run_request(word, 1'b0))
            begin
                word           = '0;
                word.operation = OP_DELETE;
            end
            send_word(word);
        end
    endtask

    // Receiver: check every accepted result word, then choose the next ready level.
    // Exactly one assignment to rsp_ready per edge keeps the level unambiguous.
    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
                shadow.check_word(rsp);
            if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (steady)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= 20);
        end
    end

    // Watchdog: count cycles with no handshake on either side and end the run at the limit
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [IDX_W-1:0] h1;
        logic [IDX_W-1:0] h2;
        logic [IDX_W-1:0] h3;
        logic [IDX_W-1:0] h4;
        shadow = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-list cases first: nothing has been written yet
        send_op(OP_DUMP, '0, '0);
        send_op(OP_RELEASE, '0, '1);
        send_op(OP_DELETE, '0, '0);

        // Build a four-node list from fresh nodes, the number extremes among them
        send_op(OP_CREATE, '0, '1);
        h1 = shadow.last_alloc;
        send_op(OP_INSERT, h1, '0);
        h2 = shadow.last_alloc;
        send_op(OP_INSERT, h2, '1);
        h3 = shadow.last_alloc;
        send_op(OP_INSERT, h3, 32'h5A5A_A5A5);
        h4 = shadow.last_alloc;
        send_op(OP_DUMP, h4, '0);

        // Unknown codes leave the pool alone
        send_op(OP_SPARE_LO, '1, '1);
        send_op(OP_SPARE_MID, 6'd21, 32'h0000_0001);
        send_op(OP_SPARE_HI, '0, '0);

        // Free one node and take it back from the free list
        send_op(OP_DELETE, h4, '0);
        send_op(OP_INSERT, h3, 32'h0000_0001);
        h4 = shadow.last_alloc;
        send_op(OP_DUMP, h4, '0);
        send_op(OP_RELEASE, h4, '0);

        // Free a node twice so that it links to itself, then dump it: the walk must stop
        // at its cap. Two creates then untangle the free list again.
        send_op(OP_CREATE, '0, '0);
        h1 = shadow.last_alloc;
        send_op(OP_DELETE, h1, '0);
        send_op(OP_DELETE, h1, '0);
        send_op(OP_DUMP, h1, '0);
        send_op(OP_CREATE, '0, '0);
        send_op(OP_CREATE, '0, '0);

        // Link to the highest index before it exists; no read happens yet
        send_op(OP_INSERT, '1, '1);

        // Grow lists until the pool runs dry
        run_random(MIX_BUILD, 70);

        // Hold off the output while requests keep coming, then tear lists down
        hold_start = 1'b1;
        run_random(MIX_TEAR, 15);

        // A stretch with no idling on either side
        steady = 1'b1;
        run_random(MIX_BLEND, 15);
        steady = 1'b0;
        req_valid <= 1'b0;

        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/llnp_pkg.sv
hdl/llnp_ram.sv
hdl/llnp_dp.sv
hdl/llnp_ctrl.sv
hdl/linked_list_node_pool_top.sv
bench/tb_linked_list_node_pool_top.sv
